// ===== rtl/core/gexq_pkg.sv =====
// Shared types and constants for the extent quantize and pack block.
// No dependencies; used by every module under rtl/core.
package gexq_pkg;

	localparam int IDX_W   = 32;           // widest index (lod 30 -> 32 bits)
	localparam int BITS_W  = 6;            // holds an index width of 2..32
	localparam int ACC_W   = IDX_W + 8;    // pending byte plus one full index
	localparam int LOD_W   = 5;
	localparam logic [LOD_W-1:0] LOD_MAX = 5'd30;
	localparam int Q_DEPTH = 4;
	localparam int Q_AW    = 2;
	localparam int Q_CW    = 3;

	// one quantized index on its way from the front to the packer
	typedef struct packed {
		logic [IDX_W-1:0]  idx_al;  // index, left aligned (MSB at bit 31)
		logic [BITS_W-1:0] bits;    // index width
		logic              last;    // closes the extents set
	} item_t;

	// queue status seen by the front and the back
	typedef struct packed {
		logic full;
		logic nonempty;
	} q_stat_t;

endpackage

// ===== rtl/core/gexq_front.sv =====
// Front of the block: clamp, scale by 2^B-1 and round one coordinate per cycle.
// Three-stage pipeline that stalls while the queue is full; depends on gexq_pkg.
module gexq_front #(
	parameter int FRAC_BITS = 24
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [31:0]                  coordinate,
	input  logic                         round_up,
	input  logic                         end_of_set,
	input  logic [gexq_pkg::LOD_W-1:0]   lod,
	input  gexq_pkg::q_stat_t            q_stat,
	output logic                         push,
	output gexq_pkg::item_t              push_item
);

	localparam int CW = (FRAC_BITS + 1 > 32) ? FRAC_BITS + 1 : 32;
	localparam int PW = CW + gexq_pkg::IDX_W;
	localparam logic [CW-1:0] ONE = CW'(1) << FRAC_BITS;

	logic adv;
	logic v_s1, v_s2, v_s3;
	logic [CW-1:0] c_s1;
	logic [PW-1:0] p_s2;
	logic up_s1, up_s2;
	logic end_s1, end_s2;
	logic [gexq_pkg::BITS_W-1:0] b_s1, b_s2;
	gexq_pkg::item_t item_s3;

	logic [CW-1:0] raw_ext, c_in;
	logic [gexq_pkg::LOD_W-1:0] lod_sat;
	logic [PW-1:0] sum_s2;
	logic [gexq_pkg::IDX_W-1:0] idx_s2;

	assign adv      = !v_s3 || !q_stat.full;
	assign in_ready = adv;
	assign push     = v_s3 && !q_stat.full;
	assign push_item = item_s3;

	always_comb begin
		raw_ext = CW'(coordinate[30:0]);
		if (coordinate[31]) begin
			c_in = '0;
		end else if (raw_ext > ONE) begin
			c_in = ONE;
		end else begin
			c_in = raw_ext;
		end
		lod_sat = (lod > gexq_pkg::LOD_MAX) ? gexq_pkg::LOD_MAX : lod;
	end

	// P + rounding, then the index sits at bit FRAC_BITS and up
	always_comb begin
		sum_s2 = p_s2 + (up_s2 ? PW'(ONE - CW'(1)) : PW'(0));
		idx_s2 = sum_s2[FRAC_BITS +: gexq_pkg::IDX_W];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			c_s1   <= c_in;
			up_s1  <= round_up;
			end_s1 <= end_of_set;
			b_s1   <= gexq_pkg::BITS_W'(lod_sat) + gexq_pkg::BITS_W'(2);
			// c * (2^B - 1) as a shift and subtract
			p_s2   <= (PW'(c_s1) << b_s1) - PW'(c_s1);
			up_s2  <= up_s1;
			end_s2 <= end_s1;
			b_s2   <= b_s1;
			item_s3.idx_al <= idx_s2 << (gexq_pkg::BITS_W'(gexq_pkg::IDX_W) - b_s2);
			item_s3.bits   <= b_s2;
			item_s3.last   <= end_s2;
		end
	end

endmodule

// ===== rtl/core/gexq_queue.sv =====
// Four-entry queue between the quantizer front and the byte packer.
// Depends on gexq_pkg for the item type and depth.
module gexq_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  gexq_pkg::item_t   push_item,
	input  logic              pop,
	output gexq_pkg::item_t   head,
	output gexq_pkg::q_stat_t stat
);

	gexq_pkg::item_t mem_q [gexq_pkg::Q_DEPTH];
	logic [gexq_pkg::Q_AW-1:0] wr_ptr_q, rd_ptr_q;
	logic [gexq_pkg::Q_CW-1:0] cnt_q;

	assign stat.full     = (cnt_q == gexq_pkg::Q_CW'(gexq_pkg::Q_DEPTH));
	assign stat.nonempty = (cnt_q != '0);
	assign head          = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			cnt_q <= cnt_q + gexq_pkg::Q_CW'(push) - gexq_pkg::Q_CW'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	property p_no_overflow;
		@(posedge clk) disable iff (!arst_n) push |-> (!stat.full || pop);
	endproperty
	a_no_overflow: assert property (p_no_overflow) else $error("queue overflow");

	property p_no_underflow;
		@(posedge clk) disable iff (!arst_n) pop |-> stat.nonempty;
	endproperty
	a_no_underflow: assert property (p_no_underflow) else $error("queue underflow");

	property p_cnt_range;
		@(posedge clk) disable iff (!arst_n) cnt_q <= gexq_pkg::Q_CW'(gexq_pkg::Q_DEPTH);
	endproperty
	a_cnt_range: assert property (p_cnt_range) else $error("queue count out of range");

endmodule

// ===== rtl/core/gexq_back.sv =====
// Back of the block: appends indices MSB first and emits one byte per cycle.
// Stalls while out_ready is low; depends on gexq_pkg; fed by gexq_queue.
module gexq_back (
	input  logic              clk,
	input  logic              arst_n,
	input  gexq_pkg::item_t   head,
	input  gexq_pkg::q_stat_t q_stat,
	output logic              pop,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [7:0]        out_byte,
	output logic              out_last
);

	localparam int AW = gexq_pkg::ACC_W;
	localparam int TW = gexq_pkg::BITS_W;

	logic          busy_q, end_q;
	logic [AW-1:0] acc_q;
	logic [TW-1:0] tot_q;
	logic          o_valid_q, o_last_q;
	logic [7:0]    o_byte_q;

	logic          adv, have, emits, step, fin;
	logic [AW-1:0] ins, cur_acc;
	logic [TW-1:0] cur_tot, rem;
	logic          cur_end;

	assign adv = !o_valid_q || out_ready;

	always_comb begin
		ins     = {head.idx_al, 8'h00} >> tot_q;
		cur_acc = busy_q ? acc_q : (acc_q | ins);
		cur_tot = busy_q ? tot_q : tot_q + head.bits;
		cur_end = busy_q ? end_q : head.last;
		have    = busy_q || q_stat.nonempty;
		emits   = (cur_tot >= TW'(8)) || cur_end;
		step    = have && (!emits || adv);
		fin     = cur_end && (cur_tot <= TW'(8));
		rem     = cur_tot - TW'(8);
	end

	assign pop = step && !busy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q    <= 1'b0;
			end_q     <= 1'b0;
			acc_q     <= '0;
			tot_q     <= '0;
			o_valid_q <= 1'b0;
		end else begin
			if (step) begin
				if (!emits) begin
					acc_q  <= cur_acc;
					tot_q  <= cur_tot;
					busy_q <= 1'b0;
				end else if (fin) begin
					acc_q  <= '0;
					tot_q  <= '0;
					busy_q <= 1'b0;
				end else begin
					acc_q  <= cur_acc << 8;
					tot_q  <= rem;
					end_q  <= cur_end;
					busy_q <= cur_end || (rem >= TW'(8));
				end
			end
			if (adv) begin
				o_valid_q <= step && emits;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			o_byte_q <= cur_acc[AW-1 -: 8];
			o_last_q <= fin;
		end
	end

	assign out_valid = o_valid_q;
	assign out_byte  = o_byte_q;
	assign out_last  = o_last_q;

	property p_idle_partial;
		@(posedge clk) disable iff (!arst_n) !busy_q |-> (tot_q < TW'(8));
	endproperty
	a_idle_partial: assert property (p_idle_partial) else $error("idle with full byte");

	property p_busy_work;
		@(posedge clk) disable iff (!arst_n)
			(busy_q && !end_q) |-> (tot_q >= TW'(8));
	endproperty
	a_busy_work: assert property (p_busy_work) else $error("busy without a byte");

	property p_last_clears;
		@(posedge clk) disable iff (!arst_n)
			(step && emits && fin) |=> (!busy_q && tot_q == '0);
	endproperty
	a_last_clears: assert property (p_last_clears) else $error("set end left bits");

endmodule

// ===== rtl/core/geom_extent_quantize_pack.sv =====
// Top level of the extent quantize and pack block.
// Instantiates gexq_front, gexq_queue and gexq_back; depends on gexq_pkg.
//
// Use:
//   s_* channel: one request per coordinate. s_tdata carries the signed fixed
//   point coordinate (FRAC_BITS fraction bits), s_tuser the round-up flag
//   (ceiling for an upper bound), s_tlast marks the final coordinate of a set.
//   m_* channel: the packed index stream of all requests, MSB first;
//   m_tlast tags the final byte of a set (a partial byte is zero padded).
//   cfg_* channel: writes lod_level (index width lod_level+2, values above
//   30 act as 30); write it only while the block is idle. Always ready.
// Path: three front stages, the queue and the output register lie between
//   an accepted coordinate and its first byte on m_tvalid.
// Throughput: the packer shifts out one byte per cycle while m_tready holds,
//   and an item completes as many bytes as B/8 rounded (4 to 5 at B = 32,
//   fewer for narrow ones); the next item is popped once those bytes are out.
// Reset: clears the pipeline, the queue, the pending partial byte and
//   lod_level. When m_tready is low the output byte holds, the four-entry
//   queue fills and then s_tready drops.
module geom_extent_quantize_pack #(
	parameter int FRAC_BITS = 24
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // [31:0] coordinate
	input  logic        s_tuser,   // [0] round_up
	input  logic        s_tlast,   // end_of_set
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,   // [7:0] packed_byte
	output logic        m_tlast,   // last_byte
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [4:0]  cfg_data   // [4:0] lod_level
);

	logic [gexq_pkg::LOD_W-1:0] lod_q;
	gexq_pkg::q_stat_t q_stat;
	gexq_pkg::item_t   push_item, head;
	logic push, pop;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lod_q <= '0;
		end else if (cfg_valid) begin
			lod_q <= cfg_data;
		end
	end

	// clamp, scale and round; pushes one left-aligned index per request
	gexq_front #(
		.FRAC_BITS(FRAC_BITS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_tvalid),
		.in_ready   (s_tready),
		.coordinate (s_tdata),
		.round_up   (s_tuser),
		.end_of_set (s_tlast),
		.lod        (lod_q),
		.q_stat     (q_stat),
		.push       (push),
		.push_item  (push_item)
	);

	// decouples the quantizer from a stalled byte sink
	gexq_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.pop       (pop),
		.head      (head),
		.stat      (q_stat)
	);

	// bit packer with the output register
	gexq_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.q_stat    (q_stat),
		.pop       (pop),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_byte  (m_tdata),
		.out_last  (m_tlast)
	);

endmodule
